// ===== sv/graph_colour_count_unit_defines.svh =====
// Assertion helpers for the module that carries checks.
`ifndef GRAPH_COLOUR_COUNT_UNIT_DEFINES_SVH
`define GRAPH_COLOUR_COUNT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define GCC_ASSERT_IMPL(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the trigger.
`define GCC_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/gcc_pkg.sv =====
package gcc_pkg;

  // Fixed field widths of the ports.
  localparam int OP_W       = 2;
  localparam int NODE_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SAT_W      = 7;

  // Saturation stops counting at this value.
  localparam logic [SAT_W-1:0] SAT_MAX = 7'd127;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_MODE = 2'd1;

endpackage

// ===== sv/gcc_popcount.sv =====
module gcc_popcount #(
  parameter int WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [WIDTH-1:0]           in_bits,
  output logic                       out_valid,
  output logic [$clog2(WIDTH+1)-1:0] out_count
);

  localparam int NG    = (WIDTH + 7) / 8;
  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [NG*8-1:0]  padded;
  logic [3:0]       grp_nxt [NG];
  logic [3:0]       grp_r   [NG];
  logic [CNT_W-1:0] sum_nxt;
  logic [CNT_W-1:0] count_r;
  logic             v1_r;
  logic             v2_r;

  assign padded = (NG*8)'(in_bits);

  // First stage: count the ones in each byte.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_nxt[g] = grp_nxt[g] + 4'(padded[g*8+b]);
      end
    end
  end

  // Second stage: add the byte counts.
  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + CNT_W'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    grp_r   <= grp_nxt;
    count_r <= sum_nxt;
  end

  assign out_valid = v2_r;
  assign out_count = count_r;

endmodule

// ===== sv/graph_colour_count_unit.sv =====
// Add edge: read-modify-write of both adjacency rows; clear: done in the idle state.
// Compute with a shortcut answer: goes straight to the finish state, which loads the output register.
// Greedy compute: one neighbor scan per vertex after vertex 0; saturation compute: degree
// pass, then one scan per coloured vertex. One item is worked at a time; in_stall is high
// meanwhile.
// Reset (rst_n, synchronous) empties the graph through per-row valid bits, no clearing pass.
`include "graph_colour_count_unit_defines.svh"
module graph_colour_count_unit
  import gcc_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [NODE_W-1:0]     in_node_a,
  input  logic [NODE_W-1:0]     in_node_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    out_colour_count,
  output logic                  out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int PC_W = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RA, S_ADD_WA, S_ADD_RB, S_ADD_WB, S_INIT, S_DEG_RD, S_DEG_WAIT,
    S_DEG_POP, S_ROW_RD, S_ROW_WAIT, S_SCAN, S_PICK, S_FINISH
  } state_t;

  state_t state_r;

  // Configuration and graph flags.
  logic [CFG_DATA_W-1:0] node_count_r;
  logic                  exact_mode_r;
  logic                  edge_present_r;
  logic                  self_loop_r;

  // Output register.
  logic                  out_valid_r;
  logic [COUNT_W-1:0]    out_colour_count_r;
  logic                  out_status_r;

  // Memories and their valid bits.
  logic [MAX_NODES-1:0]  adj_mem [MAX_NODES];
  logic [CW-1:0]         col_mem [MAX_NODES];
  logic [SAT_W-1:0]      sat_mem [MAX_NODES];
  logic [NW-1:0]         deg_mem [MAX_NODES];
  logic [MAX_NODES-1:0]  row_vld_r;
  logic [MAX_NODES-1:0]  col_vld_r;
  logic [MAX_NODES-1:0]  sat_vld_r;

  logic [MAX_NODES-1:0]  adj_rdata_r;
  logic                  adj_rvld_r;
  logic [CW-1:0]         col_rdata_r;
  logic                  col_rvld_r;
  logic [SAT_W-1:0]      sat_rdata_r;
  logic                  sat_rvld_r;
  logic [NW-1:0]         deg_rdata_r;

  // Sequencer working registers.
  logic [NW-1:0]         a_r;
  logic [NW-1:0]         b_r;
  logic [NW-1:0]         cur_r;
  logic [NW-1:0]         deg_i_r;
  logic [CW-1:0]         step_r;
  logic [CW-1:0]         scan_i_r;
  logic                  pv_r;
  logic [NW-1:0]         pi_r;
  logic [MAX_NODES-1:0]  used_r;
  logic [MAX_NODES-1:0]  row_r;
  logic [NW-1:0]         sel_r;
  logic [SAT_W-1:0]      best_sat_r;
  logic [NW-1:0]         best_deg_r;
  logic [CW-1:0]         max_r;
  logic [CW-1:0]         res_r;

  // Combinational helpers.
  logic [CW-1:0]         n_live;
  logic [MAX_NODES-1:0]  live_mask;
  logic [MAX_NODES-1:0]  row_eff;
  logic [MAX_NODES-1:0]  free_bits;
  logic [CW-1:0]         pick_colour;
  logic [CW-1:0]         max_nxt;
  logic [NW-1:0]         adj_ra;
  logic                  adj_we;
  logic [NW-1:0]         adj_wa;
  logic [MAX_NODES-1:0]  adj_wd;
  logic [NW-1:0]         rd_idx;
  logic                  col_we;
  logic [NW-1:0]         col_wa;
  logic [CW-1:0]         col_wd;
  logic                  sat_we;
  logic [SAT_W-1:0]      sat_val;
  logic [SAT_W-1:0]      sat_upd;
  logic [CW-1:0]         col_val;
  logic                  nb;
  logic                  sel_take;
  logic                  pc_in_valid;
  logic                  pc_out_valid;
  logic [PC_W-1:0]       pc_count;
  logic [NW-1:0]         pc_deg;

  // Effective vertex count, clamped to the legal range.
  always_comb begin
    if (node_count_r == '0) begin
      n_live = CW'(1);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_live = CW'(MAX_NODES);
    end else begin
      n_live = CW'(node_count_r);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      live_mask[k] = (k < int'(n_live));
    end
  end

  // A row never written since the last clear reads as empty.
  assign row_eff = adj_rvld_r ? adj_rdata_r : '0;

  // Lowest free colour from the neighbor colour set.
  assign free_bits = ~used_r & (used_r + 1'b1);

  always_comb begin
    pick_colour = '0;
    if (free_bits == '0) begin
      pick_colour = CW'(MAX_NODES);
    end
    for (int k = 0; k < MAX_NODES; k++) begin
      if (free_bits[k]) begin
        pick_colour = pick_colour | CW'(k + 1);
      end
    end
  end

  assign max_nxt = (pick_colour > max_r) ? pick_colour : max_r;

  // Adjacency read address and write port.
  always_comb begin
    unique case (state_r)
      S_ADD_RA: adj_ra = a_r;
      S_ADD_RB: adj_ra = b_r;
      S_DEG_RD: adj_ra = deg_i_r;
      S_ROW_RD: adj_ra = cur_r;
      default:  adj_ra = '0;
    endcase
  end

  always_comb begin
    adj_we = 1'b0;
    adj_wa = a_r;
    adj_wd = row_eff | (MAX_NODES'(1) << b_r);
    if (state_r == S_ADD_WA) begin
      adj_we = 1'b1;
    end else if (state_r == S_ADD_WB) begin
      adj_we = 1'b1;
      adj_wa = b_r;
      adj_wd = row_eff | (MAX_NODES'(1) << a_r);
    end
  end

  // Scan read address for the colour, saturation and degree memories.
  assign rd_idx = (scan_i_r < n_live) ? scan_i_r[NW-1:0] : '0;

  // Per-neighbor work on the beat returned by the scan.
  assign nb      = row_r[pi_r];
  assign col_val = col_rvld_r ? col_rdata_r : '0;
  assign sat_val = sat_rvld_r ? sat_rdata_r : SAT_W'(1);

  always_comb begin
    if (pi_r == cur_r) begin
      sat_upd = '0;
    end else if (nb && sat_val != '0 && sat_val < SAT_MAX) begin
      sat_upd = sat_val + 1'b1;
    end else begin
      sat_upd = sat_val;
    end
  end

  assign sel_take = (pi_r == '0) || (sat_upd > best_sat_r) ||
                    ((sat_upd == best_sat_r) && (deg_rdata_r >= best_deg_r));

  assign sat_we = (state_r == S_SCAN) && pv_r && exact_mode_r;

  // Colour memory write: vertex 0 preset for greedy, else the picked colour.
  always_comb begin
    col_we = 1'b0;
    col_wa = cur_r;
    col_wd = pick_colour;
    if (state_r == S_INIT && !exact_mode_r) begin
      col_we = 1'b1;
      col_wa = '0;
      col_wd = CW'(1);
    end else if (state_r == S_PICK) begin
      col_we = 1'b1;
    end
  end

  // Degree counter for the saturation start.
  assign pc_in_valid = (state_r == S_DEG_WAIT);
  assign pc_deg      = NW'(pc_count);

  gcc_popcount #(
    .WIDTH (MAX_NODES)
  ) u_popcount (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pc_in_valid),
    .in_bits   (row_eff & live_mask),
    .out_valid (pc_out_valid),
    .out_count (pc_count)
  );

  // Memories.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rdata_r <= adj_mem[adj_ra];
    adj_rvld_r  <= row_vld_r[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    col_rdata_r <= col_mem[rd_idx];
    col_rvld_r  <= col_vld_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (sat_we) begin
      sat_mem[pi_r] <= sat_upd;
    end
    sat_rdata_r <= sat_mem[rd_idx];
    sat_rvld_r  <= sat_vld_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DEG_POP && pc_out_valid) begin
      deg_mem[deg_i_r] <= pc_deg;
    end
    deg_rdata_r <= deg_mem[rd_idx];
  end

  // Sequencer, flags and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      node_count_r   <= CFG_DATA_W'(1);
      exact_mode_r   <= 1'b0;
      edge_present_r <= 1'b0;
      self_loop_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      row_vld_r      <= '0;
      col_vld_r      <= '0;
      sat_vld_r      <= '0;
      pv_r           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODE_COUNT) begin
          node_count_r <= cfg_data;
        end else if (cfg_index == CFG_EXACT_MODE) begin
          exact_mode_r <= cfg_data[0];
        end
      end

      // A new result loads the output register; a taken beat empties it.
      if (state_r == S_FINISH && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_operation)
              OP_ADD_EDGE: begin
                if (!self_loop_r && int'(in_node_a) < MAX_NODES &&
                    int'(in_node_b) < MAX_NODES) begin
                  edge_present_r <= 1'b1;
                  if (in_node_a == in_node_b) begin
                    self_loop_r <= 1'b1;
                  end else begin
                    a_r     <= in_node_a[NW-1:0];
                    b_r     <= in_node_b[NW-1:0];
                    state_r <= S_ADD_RA;
                  end
                end
              end
              OP_COMPUTE: begin
                if (!edge_present_r || n_live == CW'(1)) begin
                  res_r   <= CW'(1);
                  state_r <= S_FINISH;
                end else if (self_loop_r) begin
                  res_r   <= '0;
                  state_r <= S_FINISH;
                end else if (n_live == CW'(2)) begin
                  res_r   <= CW'(2);
                  state_r <= S_FINISH;
                end else begin
                  state_r <= S_INIT;
                end
              end
              OP_CLEAR: begin
                row_vld_r      <= '0;
                edge_present_r <= 1'b0;
                self_loop_r    <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_RA: state_r <= S_ADD_WA;
        S_ADD_WA: begin
          row_vld_r[a_r] <= 1'b1;
          state_r        <= S_ADD_RB;
        end
        S_ADD_RB: state_r <= S_ADD_WB;
        S_ADD_WB: begin
          row_vld_r[b_r] <= 1'b1;
          state_r        <= S_IDLE;
        end
        S_INIT: begin
          sat_vld_r <= '0;
          max_r     <= CW'(1);
          if (exact_mode_r) begin
            col_vld_r  <= '0;
            deg_i_r    <= '0;
            best_deg_r <= '0;
            cur_r      <= '0;
            state_r    <= S_DEG_RD;
          end else begin
            // Only vertex 0 starts coloured in greedy mode.
            col_vld_r <= MAX_NODES'(1);
            cur_r     <= NW'(1);
            state_r   <= S_ROW_RD;
          end
        end
        S_DEG_RD:   state_r <= S_DEG_WAIT;
        S_DEG_WAIT: state_r <= S_DEG_POP;
        S_DEG_POP: begin
          if (pc_out_valid) begin
            if (pc_deg > best_deg_r) begin
              best_deg_r <= pc_deg;
              cur_r      <= deg_i_r;
            end
            if (CW'(deg_i_r) == n_live - 1'b1) begin
              step_r  <= '0;
              state_r <= S_ROW_RD;
            end else begin
              deg_i_r <= deg_i_r + 1'b1;
              state_r <= S_DEG_RD;
            end
          end
        end
        S_ROW_RD: state_r <= S_ROW_WAIT;
        S_ROW_WAIT: begin
          row_r    <= row_eff;
          used_r   <= '0;
          scan_i_r <= '0;
          state_r  <= S_SCAN;
        end
        S_SCAN: begin
          // Issue one vertex a cycle; its data returns on the next beat.
          pv_r <= (scan_i_r < n_live);
          if (scan_i_r < n_live) begin
            pi_r     <= rd_idx;
            scan_i_r <= scan_i_r + 1'b1;
          end
          if (pv_r) begin
            if (nb && col_val != '0) begin
              used_r[NW'(col_val - 1'b1)] <= 1'b1;
            end
            if (exact_mode_r) begin
              sat_vld_r[pi_r] <= 1'b1;
              if (sel_take) begin
                sel_r      <= pi_r;
                best_sat_r <= sat_upd;
                best_deg_r <= deg_rdata_r;
              end
            end
            if (CW'(pi_r) == n_live - 1'b1) begin
              state_r <= S_PICK;
            end
          end
        end
        S_PICK: begin
          col_vld_r[cur_r] <= 1'b1;
          max_r            <= max_nxt;
          if (!exact_mode_r) begin
            if (CW'(cur_r) == n_live - 1'b1) begin
              res_r   <= max_nxt;
              state_r <= S_FINISH;
            end else begin
              cur_r   <= cur_r + 1'b1;
              state_r <= S_ROW_RD;
            end
          end else begin
            if (best_sat_r == '0 || step_r == n_live - 1'b1) begin
              res_r   <= max_nxt;
              state_r <= S_FINISH;
            end else begin
              step_r  <= step_r + 1'b1;
              cur_r   <= sel_r;
              state_r <= S_ROW_RD;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_colour_count_r <= COUNT_W'(res_r);
            out_status_r       <= self_loop_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_colour_count = out_colour_count_r;
  assign out_status       = out_status_r;

  // Checks on the sequencer.
  `GCC_ASSERT_IMPL(a_pick_in_range, clk, rst_n, state_r == S_PICK, pick_colour <= n_live)
  `GCC_ASSERT_IMPL(a_loop_implies_edge, clk, rst_n, self_loop_r, edge_present_r)
  `GCC_ASSERT_IMPL(a_no_scan_with_loop, clk, rst_n, state_r == S_SCAN, !self_loop_r)
  `GCC_ASSERT_NEXT(a_compute_leaves_idle, clk, rst_n, state_r == S_IDLE && in_valid && in_operation == OP_COMPUTE, state_r == S_INIT || state_r == S_FINISH)

endmodule

// ===== tb/graph_colour_count_checker.sv =====
`timescale 1ns / 1ps
module graph_colour_count_checker
  import gcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [NODE_W-1:0]     in_node_a,
  input  logic [NODE_W-1:0]     in_node_b,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COUNT_W-1:0]    out_colour_count,
  input  logic                  out_status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int VERTICES = 64;

  typedef struct packed {
    logic [COUNT_W-1:0] colour_count;
    logic               status;
  } colour_result_t;

  colour_result_t expected_colourings[$];

  // Shadow copy of the graph and the registers.
  logic [VERTICES-1:0]   adj_rows [VERTICES];
  logic [COUNT_W-1:0]    vert_colour [VERTICES];
  logic [SAT_W-1:0]      sat_level [VERTICES];
  logic                  any_edge;
  logic                  loop_held;
  logic [CFG_DATA_W-1:0] node_count_reg;
  logic                  exact_mode_reg;

  assign pending = expected_colourings.size();

  function automatic void wipe_graph();
    for (int i = 0; i < VERTICES; i++) begin
      adj_rows[i] = '0;
      vert_colour[i] = '0;
      sat_level[i] = 7'd1;
    end
    any_edge = 1'b0;
    loop_held = 1'b0;
  endfunction

  // Smallest colour from 1 not held by a coloured neighbor of v.
  function automatic logic [COUNT_W-1:0] first_free_colour(int v, int n);
    logic [VERTICES-1:0] taken;
    taken = '0;
    for (int i = 0; i < n; i++)
      if (adj_rows[v][i] && vert_colour[i] != 0)
        taken[(vert_colour[i] - 1) % VERTICES] = 1'b1;
    for (int c = 0; c < VERTICES; c++)
      if (!taken[c]) return COUNT_W'(c + 1);
    return COUNT_W'(VERTICES);
  endfunction

  function automatic int live_degree(int v, logic [VERTICES-1:0] live);
    return $countones(adj_rows[v] & live);
  endfunction

  function automatic void saturation_colouring(int n);
    logic [VERTICES-1:0] live;
    int cur, top_deg, sel, top_sat;
    live = (n >= VERTICES) ? '1 : ((VERTICES'(1) << n) - 1);
    cur = 0;
    top_deg = 0;
    for (int i = 0; i < VERTICES; i++) begin
      vert_colour[i] = '0;
      sat_level[i] = 7'd1;
    end
    for (int i = 0; i < n; i++)
      if (live_degree(i, live) > top_deg) begin
        top_deg = live_degree(i, live);
        cur = i;
      end
    for (int step = 0; step < n; step++) begin
      vert_colour[cur] = first_free_colour(cur, n);
      sat_level[cur] = '0;
      for (int i = 0; i < n; i++)
        if (adj_rows[cur][i] && sat_level[i] != 0 && sat_level[i] < SAT_MAX)
          sat_level[i] = sat_level[i] + 1'b1;
      // Highest saturation wins; ties go to higher degree, then higher index.
      sel = 0;
      top_sat = sat_level[0];
      for (int i = 1; i < n; i++)
        if (sat_level[i] > top_sat || (sat_level[i] == top_sat &&
            live_degree(i, live) >= live_degree(sel, live))) begin
          sel = i;
          top_sat = sat_level[i];
        end
      if (top_sat == 0) break;
      cur = sel;
    end
  endfunction

  function automatic colour_result_t predict_colouring();
    colour_result_t r;
    int n;
    n = node_count_reg;
    if (n < 1) n = 1;
    if (n > VERTICES) n = VERTICES;
    r.status = loop_held;
    if (!any_edge || n == 1) r.colour_count = 7'd1;
    else if (loop_held) r.colour_count = 7'd0;
    else if (n == 2) r.colour_count = 7'd2;
    else begin
      if (exact_mode_reg) saturation_colouring(n);
      else begin
        for (int i = 0; i < VERTICES; i++) vert_colour[i] = '0;
        vert_colour[0] = 7'd1;
        for (int u = 1; u < n; u++) vert_colour[u] = first_free_colour(u, n);
      end
      r.colour_count = 7'd1;
      for (int i = 0; i < n; i++)
        if (vert_colour[i] > r.colour_count) r.colour_count = vert_colour[i];
    end
    return r;
  endfunction

  // Results are checked before new beats are predicted, so a fresh
  // expectation is never taken by an older result.
  always @(posedge clk) begin
    colour_result_t want;
    if (!rst_n) begin
      wipe_graph();
      node_count_reg = 7'd1;
      exact_mode_reg = 1'b0;
      expected_colourings.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_colourings.size() == 0) begin
          $error("result beat with no expectation: colour_count %0d status %0d",
                 out_colour_count, out_status);
          mismatches++;
        end else begin
          want = expected_colourings.pop_front();
          if (out_colour_count !== want.colour_count) begin
            $error("colour_count: expected %0d, got %0d", want.colour_count,
                   out_colour_count);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODE_COUNT) node_count_reg = cfg_data;
        else if (cfg_index == CFG_EXACT_MODE) exact_mode_reg = cfg_data[0];
      end
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_ADD_EDGE: begin
            if (!loop_held) begin
              any_edge = 1'b1;
              if (in_node_a == in_node_b) loop_held = 1'b1;
              else begin
                adj_rows[in_node_a][in_node_b] = 1'b1;
                adj_rows[in_node_b][in_node_a] = 1'b1;
              end
            end
          end
          OP_CLEAR: wipe_graph();
          OP_COMPUTE: begin
            want = predict_colouring();
            expected_colourings = {expected_colourings, want};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import gcc_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = OP_CLEAR;
  logic [NODE_W-1:0]     in_node_a = '0;
  logic [NODE_W-1:0]     in_node_b = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_W-1:0]    out_colour_count;
  logic                  out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_NODE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    pending;
  int                    cycle_count = 0;
  bit                    sender_idles = 1'b1;
  bit                    receiver_idles = 1'b1;
  bit                    hold_request = 1'b0;
  int                    live_n = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  graph_colour_count_unit dut (.*);

  graph_colour_count_checker checker_inst (.*);

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    int hold_left;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_idles && ($urandom_range(99) < 34);
    end
  end

  // Offer one beat and hold it until taken.
  task automatic send_beat(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                           logic [NODE_W-1:0] b);
    if (sender_idles && $urandom_range(99) < 34 && in_valid) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_node_a <= a;
    in_node_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    // Adds have finished once in_stall is low; this wait is extra margin.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] n, logic mode);
    drain();
    write_reg(CFG_NODE_COUNT, n);
    write_reg(CFG_EXACT_MODE, mode);
    live_n = (n == 0) ? 1 : (n > 64) ? 64 : n;
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(99) < 8) return NODE_W'($urandom_range(63));
    return NODE_W'($urandom_range(live_n - 1));
  endfunction

  // One random beat of a well-formed edge load, with some noise.
  task automatic random_beat();
    int roll;
    logic [NODE_W-1:0] a;
    roll = $urandom_range(99);
    a = pick_node();
    if (roll < 2) send_beat(OP_ADD_EDGE, a, a);
    else if (roll < 80) send_beat(OP_ADD_EDGE, a, pick_node());
    else if (roll < 92) send_beat(OP_COMPUTE, NODE_W'($urandom), NODE_W'($urandom));
    else if (roll < 97) send_beat(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
    else send_beat(OP_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
  endtask

  initial begin
    int n_pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, shortcuts, ignored items and extremes.
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    configure(7'd5, 1'b0);
    send_beat(OP_COMPUTE, 6'd63, 6'd63);
    send_beat(OP_ADD_EDGE, 6'd0, 6'd1);
    send_beat(OP_ADD_EDGE, 6'd63, 6'd62);
    send_beat(OP_ADD_EDGE, 6'd1, 6'd2);
    send_beat(OP_ADD_EDGE, 6'd2, 6'd0);
    send_beat(OP_UNUSED, 6'd3, 6'd4);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    send_beat(OP_ADD_EDGE, 6'd2, 6'd2);
    send_beat(OP_ADD_EDGE, 6'd3, 6'd4);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    send_beat(OP_CLEAR, 6'd0, 6'd0);
    configure(7'd2, 1'b1);
    send_beat(OP_ADD_EDGE, 6'd0, 6'd1);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    configure(7'd0, 1'b0);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    configure(7'd127, 1'b1);
    send_beat(OP_ADD_EDGE, 6'd0, 6'd63);
    send_beat(OP_ADD_EDGE, 6'd63, 6'd0);
    send_beat(OP_ADD_EDGE, 6'd63, 6'd31);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    configure(7'd64, 1'b0);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);
    send_beat(OP_CLEAR, 6'd0, 6'd0);
    send_beat(OP_COMPUTE, 6'd0, 6'd0);

    // Random phases, each under its own settings.
    for (int phase = 0; phase < 10; phase++) begin
      n_pick = $urandom_range(99);
      if (phase == 3) n_pick = 64;
      else if (phase == 7) n_pick = 127;
      else if (n_pick < 6) n_pick = $urandom_range(0, 2);
      else if (n_pick < 10) n_pick = 64;
      else n_pick = $urandom_range(3, 14);
      configure(CFG_DATA_W'(n_pick), phase == 3 ? 1'b1 : 1'($urandom));
      sender_idles = (phase != 5);
      receiver_idles = (phase != 5);
      if (phase == 2) hold_request = 1'b1;
      if ($urandom_range(1)) send_beat(OP_CLEAR, 6'd0, 6'd0);
      for (int k = 0; k < 110; k++) begin
        random_beat();
        // Sender pauses mid-phase until every result is back.
        if (phase == 4 && k == 50) drain();
      end
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
